// ----- src/wucd_pkg.sv -----
// shared types, constants and register codes of the uniform colour led driver
// no dependencies; used by every other file of the block
`default_nettype none

package wucd_pkg;

  // width of the led count register
  localparam int LED_COUNT_BITS = 16;
  localparam int POS_W          = LED_COUNT_BITS + 1;
  localparam int HIGH_W         = 15;
  localparam int TICK_W         = 16;
  localparam int LATCH_W        = 8;
  localparam int COLOUR_W       = 24;
  localparam int BIT_W          = 5;
  localparam int CFG_DATA_W     = (LED_COUNT_BITS > HIGH_W) ? LED_COUNT_BITS : HIGH_W;
  localparam int CFG_IDX_W      = 3;

  // index of the last bit slot of a led, msb first
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(COLOUR_W - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH_LEDS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 3'd4;

  // reset values of the registers
  localparam logic [LED_COUNT_BITS-1:0] RST_LED_COUNT  = LED_COUNT_BITS'(600);
  localparam logic [HIGH_W-1:0]         RST_ZERO_HIGH  = 15'd17;
  localparam logic [HIGH_W-1:0]         RST_ONE_HIGH   = 15'd34;
  localparam logic [LATCH_W-1:0]        RST_LATCH_LEDS = 8'd5;

  typedef struct packed {
    logic [LED_COUNT_BITS-1:0] led_count;
    logic [HIGH_W-1:0]         zero_high_ticks;
    logic [HIGH_W-1:0]         one_high_ticks;
    logic [LATCH_W-1:0]        latch_leds;
    logic                      invert_output;
  } cfg_t;

  typedef struct packed {
    logic data_line;
    logic busy_res;
    logic start_refused;
  } res_t;

endpackage

`default_nettype wire

// ----- src/wucd_ifs.sv -----
// valid/ready channels of the uniform colour led driver: command items and results
// depends on wucd_pkg for field widths
`default_nettype none

interface wucd_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [wucd_pkg::COLOUR_W-1:0]    colour_word;

  modport source (output valid, output mode, output colour_word, input ready);
  modport sink   (input valid, input mode, input colour_word, output ready);
endinterface

interface wucd_out_if;
  logic valid;
  logic ready;
  logic data_line;
  logic busy_res;
  logic start_refused;

  modport source (output valid, output data_line, output busy_res, output start_refused,
                  input ready);
  modport sink   (input valid, input data_line, input busy_res, input start_refused,
                  output ready);
endinterface

`default_nettype wire

// ----- src/ws2812_uniform_colour_driver.sv -----
// top level of the uniform colour led driver: input register, core, result register
// depends on wucd_pkg, wucd_ifs, wucd_cfg_regs and wucd_core
`default_nettype none

//  channel   | dir | transfer when          | payload
//  ----------+-----+------------------------+------------------------------------
//  items     | in  | valid && ready         | mode, colour_word
//  results   | out | valid && ready         | data_line, busy_res, start_refused
//  cfg port  | in  | cfg_write_en           | cfg_index, cfg_data
//
//  one item per clock sustained while results are taken; each item passes through
//  the input register, then the result register, one result per item
//  the waveform state updates once per item, when it moves from the input
//  register into the result register
//  a stall on results holds the result register; the input register still
//  takes one more item, after which items.ready drops
//  rst is synchronous: state idle, registers at their defaults, no items in flight

module ws2812_uniform_colour_driver (
  input  wire logic                             clk,
  input  wire logic                             rst,
  wucd_in_if.sink                               items,
  wucd_out_if.source                            results,
  input  wire logic                             cfg_write_en,
  input  wire logic [wucd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wucd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  wucd_pkg::cfg_t cfg;
  wucd_pkg::res_t core_res;
  wucd_pkg::res_t res_q;

  // input register
  logic                          stage_valid;
  logic                          stage_mode;
  logic [wucd_pkg::COLOUR_W-1:0] stage_colour;

  // result register
  logic res_valid;

  logic res_free;
  logic step;
  logic take;

  assign res_free    = !res_valid || results.ready;
  assign step        = stage_valid && res_free;   // item moves into the result register
  assign items.ready = !stage_valid || res_free;
  assign take        = items.valid && items.ready;

  wucd_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  wucd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .mode        (stage_mode),
    .colour_word (stage_colour),
    .cfg         (cfg),
    .res         (core_res)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      stage_mode   <= items.mode;
      stage_colour <= items.colour_word;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= core_res;
    end
  end

  assign results.valid         = res_valid;
  assign results.data_line     = res_q.data_line;
  assign results.busy_res      = res_q.busy_res;
  assign results.start_refused = res_q.start_refused;

endmodule

`default_nettype wire

// ----- src/wucd_cfg_regs.sv -----
// configuration register bank of the uniform colour led driver
// depends on wucd_pkg for register codes, widths and reset values
`default_nettype none

module wucd_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write_en,
  input  wire logic [wucd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wucd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output wucd_pkg::cfg_t                           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_count       <= wucd_pkg::RST_LED_COUNT;
      cfg.zero_high_ticks <= wucd_pkg::RST_ZERO_HIGH;
      cfg.one_high_ticks  <= wucd_pkg::RST_ONE_HIGH;
      cfg.latch_leds      <= wucd_pkg::RST_LATCH_LEDS;
      cfg.invert_output   <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        wucd_pkg::CFG_LED_COUNT:  cfg.led_count <= cfg_data[wucd_pkg::LED_COUNT_BITS-1:0];
        wucd_pkg::CFG_ZERO_HIGH:  cfg.zero_high_ticks <= cfg_data[wucd_pkg::HIGH_W-1:0];
        wucd_pkg::CFG_ONE_HIGH:   cfg.one_high_ticks <= cfg_data[wucd_pkg::HIGH_W-1:0];
        wucd_pkg::CFG_LATCH_LEDS: cfg.latch_leds <= cfg_data[wucd_pkg::LATCH_W-1:0];
        wucd_pkg::CFG_INVERT:     cfg.invert_output <= cfg_data[0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/wucd_core.sv -----
// waveform state and per-item logic of the uniform colour led driver
// depends on wucd_pkg for widths, cfg_t and res_t
`default_nettype none

module wucd_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              step,
  input  wire logic                              mode,
  input  wire logic [wucd_pkg::COLOUR_W-1:0]     colour_word,
  input  wire wucd_pkg::cfg_t                    cfg,
  output wucd_pkg::res_t                         res
);

  logic [wucd_pkg::COLOUR_W-1:0] held_colour;
  logic [wucd_pkg::TICK_W-1:0]   tick_in_slot;
  logic [wucd_pkg::BIT_W-1:0]    bit_in_led;
  logic [wucd_pkg::POS_W-1:0]    led_position;
  logic                          running;

  logic [wucd_pkg::COLOUR_W-1:0] held_colour_next;
  logic [wucd_pkg::TICK_W-1:0]   tick_in_slot_next;
  logic [wucd_pkg::BIT_W-1:0]    bit_in_led_next;
  logic [wucd_pkg::POS_W-1:0]    led_position_next;
  logic                          running_next;

  // state as seen by this item: fresh after an accepted start
  logic                          start_ok;
  logic [wucd_pkg::COLOUR_W-1:0] v_colour;
  logic [wucd_pkg::TICK_W-1:0]   v_tick;
  logic [wucd_pkg::BIT_W-1:0]    v_bit;
  logic [wucd_pkg::POS_W-1:0]    v_pos;
  logic                          v_running;
  logic                          cur_bit;
  logic [wucd_pkg::HIGH_W-1:0]   high_ticks;
  logic                          level;

  logic [wucd_pkg::TICK_W-1:0]   period;
  logic [wucd_pkg::TICK_W:0]     tick_inc;
  logic [wucd_pkg::POS_W-1:0]    pos_inc;
  logic [wucd_pkg::POS_W-1:0]    end_pos;

  always_comb begin
    start_ok  = mode && !running;
    v_colour  = start_ok ? colour_word : held_colour;
    v_tick    = start_ok ? '0 : tick_in_slot;
    v_bit     = start_ok ? '0 : bit_in_led;
    v_pos     = start_ok ? '0 : led_position;
    v_running = running || start_ok;

    cur_bit    = v_colour[wucd_pkg::LAST_BIT - v_bit];
    high_ticks = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
    level      = v_running && (v_pos < {1'b0, cfg.led_count}) &&
                 (v_tick < {1'b0, high_ticks});

    res.data_line     = level ^ cfg.invert_output;
    res.busy_res      = v_running;
    res.start_refused = mode && running;
  end

  // next state: load on an accepted start, else tick advance
  always_comb begin
    period   = {1'b0, cfg.zero_high_ticks} + {1'b0, cfg.one_high_ticks} + 16'd1;
    tick_inc = {1'b0, tick_in_slot} + 17'd1;
    pos_inc  = led_position + wucd_pkg::POS_W'(1);
    end_pos  = {1'b0, cfg.led_count} + wucd_pkg::POS_W'(cfg.latch_leds);

    held_colour_next  = held_colour;
    tick_in_slot_next = tick_in_slot;
    bit_in_led_next   = bit_in_led;
    led_position_next = led_position;
    running_next      = running;

    if (start_ok) begin
      held_colour_next  = colour_word;
      tick_in_slot_next = '0;
      bit_in_led_next   = '0;
      led_position_next = '0;
      running_next      = 1'b1;
    end else if (!mode && running) begin
      if (tick_inc < {1'b0, period}) begin
        tick_in_slot_next = tick_inc[wucd_pkg::TICK_W-1:0];
      end else begin
        tick_in_slot_next = '0;
        if (bit_in_led < wucd_pkg::LAST_BIT) begin
          bit_in_led_next = bit_in_led + wucd_pkg::BIT_W'(1);
        end else begin
          bit_in_led_next = '0;
          if (pos_inc >= end_pos) begin
            running_next      = 1'b0;
            led_position_next = '0;
          end else begin
            led_position_next = pos_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_colour  <= '0;
      tick_in_slot <= '0;
      bit_in_led   <= '0;
      led_position <= '0;
      running      <= 1'b0;
    end else if (step) begin
      held_colour  <= held_colour_next;
      tick_in_slot <= tick_in_slot_next;
      bit_in_led   <= bit_in_led_next;
      led_position <= led_position_next;
      running      <= running_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench of ws2812_uniform_colour_driver: tick and start items in,
// line level, busy and refused flags out, each checked against an item-level predictor
// depends on wucd_pkg, wucd_ifs and the driver rtl

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wucd_pkg::*;

  // item kinds on the mode field
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  // stimulus stops once this many items have been queued in total
  localparam int RANDOM_ITEMS = 500;
  // receiver hold-off for the back-pressure test, in cycles
  localparam int HOLD_CYCLES  = 48;
  localparam int HOLD_EVERY   = 250;

  typedef struct packed {
    logic                mode;
    logic [COLOUR_W-1:0] colour;
  } cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wucd_in_if  cmd_ch ();
  wucd_out_if res_ch ();

  ws2812_uniform_colour_driver u_top (
    .clk          (clk),
    .rst          (rst),
    .items        (cmd_ch),
    .results      (res_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: shadow copy of the registers and of the waveform state
  // ---------------------------------------------------------------------------
  cfg_t                  line_cfg;
  logic                  wave_running;
  logic [COLOUR_W-1:0]   held_rgb;
  logic [TICK_W-1:0]     slot_tick;
  logic [BIT_W-1:0]      bit_idx;
  logic [POS_W-1:0]      led_pos;

  // level of the line for the current tick, before inversion
  function automatic logic raw_line();
    logic        bit_val;
    int unsigned high_ticks;
    if (!wave_running || int'(led_pos) >= int'(line_cfg.led_count)) return 1'b0;
    // latch slots and idle fall through above; msb of the colour goes first
    bit_val    = held_rgb[COLOUR_W - 1 - int'(bit_idx)];
    high_ticks = bit_val ? int'(line_cfg.one_high_ticks) : int'(line_cfg.zero_high_ticks);
    return int'(slot_tick) < high_ticks;
  endfunction

  // move the waveform on by one tick
  function automatic void advance_tick();
    int unsigned period;
    period = int'(line_cfg.zero_high_ticks) + int'(line_cfg.one_high_ticks) + 1;
    if (!wave_running) return;
    // a slot already past a shortened period ends on this tick
    if (int'(slot_tick) + 1 < period) begin
      slot_tick = slot_tick + 1'b1;
      return;
    end
    slot_tick = '0;
    bit_idx   = bit_idx + 1'b1;
    if (int'(bit_idx) < COLOUR_W) return;
    bit_idx = '0;
    led_pos = led_pos + 1'b1;
    // data leds and latch gap both done: back to idle
    if (int'(led_pos) >= int'(line_cfg.led_count) + int'(line_cfg.latch_leds)) begin
      wave_running = 1'b0;
      led_pos      = '0;
    end
  endfunction

  // expected result of one accepted item; updates the shadow state
  function automatic res_t predict_item(logic mode_bit, logic [COLOUR_W-1:0] rgb);
    res_t r;
    r.start_refused = 1'b0;
    if (mode_bit == MODE_START) begin
      // a start while busy is dropped and flagged, no tick passes either way
      if (wave_running) begin
        r.start_refused = 1'b1;
      end else begin
        held_rgb     = rgb;
        slot_tick    = '0;
        bit_idx      = '0;
        led_pos      = '0;
        wave_running = 1'b1;
      end
      r.data_line = raw_line() ^ line_cfg.invert_output;
      r.busy_res  = wave_running;
    end else begin
      r.data_line = raw_line() ^ line_cfg.invert_output;
      r.busy_res  = wave_running;
      advance_tick();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard
  // ---------------------------------------------------------------------------
  res_t line_expect_q[$];
  cmd_t pend_items[$];
  int   mismatch_count = 0;
  int   results_done   = 0;
  int   queued_items   = 0;
  logic cmd_took       = 1'b0;
  logic res_took       = 1'b0;

  task automatic note_error(string msg);
    mismatch_count++;
    $display("ERROR result %0d: %s", results_done, msg);
  endtask

  // rising edge: record item transfers into the predictor, check result transfers
  always @(posedge clk) begin
    res_t want;
    cmd_took <= !rst && cmd_ch.valid && cmd_ch.ready;
    res_took <= !rst && res_ch.valid && res_ch.ready;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        line_expect_q.push_back(predict_item(cmd_ch.mode, cmd_ch.colour_word));
      end
      if (res_ch.valid && res_ch.ready) begin
        results_done <= results_done + 1;
        if (line_expect_q.size() == 0) begin
          note_error("result transfer with nothing pending");
        end else begin
          want = line_expect_q.pop_front();
          if (res_ch.data_line !== want.data_line)
            note_error($sformatf("data_line got %b want %b", res_ch.data_line,
                                 want.data_line));
          if (res_ch.busy_res !== want.busy_res)
            note_error($sformatf("busy_res got %b want %b", res_ch.busy_res,
                                 want.busy_res));
          if (res_ch.start_refused !== want.start_refused)
            note_error($sformatf("start_refused got %b want %b", res_ch.start_refused,
                                 want.start_refused));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item driver: falling edge, fed from pend_items
  // ---------------------------------------------------------------------------
  int send_gap    = 0;
  int send_steady = 0;

  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid       <= 1'b0;
      cmd_ch.mode        <= MODE_TICK;
      cmd_ch.colour_word <= '0;
    end else begin
      // front item went across on the last rising edge
      if (cmd_took) begin
        void'(pend_items.pop_front());
        if (send_steady > 0) begin
          send_steady--;
          send_gap = 0;
        end else begin
          send_gap = $urandom_range(0, 3);
          // now and then a run of back-to-back transfers
          if ($urandom_range(0, 15) == 0) send_steady = $urandom_range(20, 60);
        end
      end
      if (send_gap > 0) begin
        send_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (pend_items.size() != 0) begin
        cmd_ch.valid       <= 1'b1;
        cmd_ch.mode        <= pend_items[0].mode;
        cmd_ch.colour_word <= pend_items[0].colour;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: per-transfer gaps plus a periodic long hold-off
  // ---------------------------------------------------------------------------
  int take_gap     = 0;
  int take_steady  = 0;
  int hold_left    = 0;
  int next_hold_at = 100;

  // long hold-off counter; the sender keeps offering so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (results_done >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_EVERY;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_took) begin
        if (take_steady > 0) begin
          take_steady--;
          take_gap = 0;
        end else begin
          take_gap = $urandom_range(0, 3);
          if ($urandom_range(0, 15) == 0) take_steady = $urandom_range(20, 60);
        end
      end
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_ticks(int n);
    cmd_t c;
    repeat (n) begin
      c.mode   = MODE_TICK;
      c.colour = COLOUR_W'($urandom());  // ignored on a tick, toggles the bus bits
      pend_items.push_back(c);
      queued_items++;
    end
  endtask

  task automatic queue_start(logic [COLOUR_W-1:0] rgb);
    cmd_t c;
    c.mode   = MODE_START;
    c.colour = rgb;
    pend_items.push_back(c);
    queued_items++;
  endtask

  // hold until every queued item is across and every result is back
  task automatic wait_drained();
    while (pend_items.size() != 0 || cmd_ch.valid || line_expect_q.size() != 0)
      @(posedge clk);
    // two-stage pipe
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_LED_COUNT:  line_cfg.led_count       = LED_COUNT_BITS'(value);
      CFG_ZERO_HIGH:  line_cfg.zero_high_ticks = HIGH_W'(value);
      CFG_ONE_HIGH:   line_cfg.one_high_ticks  = HIGH_W'(value);
      CFG_LATCH_LEDS: line_cfg.latch_leds      = LATCH_W'(value);
      CFG_INVERT:     line_cfg.invert_output   = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int unsigned leds, int unsigned zero_hi, int unsigned one_hi,
                               int unsigned latch, int unsigned inv);
    write_reg(CFG_LED_COUNT, leds);
    write_reg(CFG_ZERO_HIGH, zero_hi);
    write_reg(CFG_ONE_HIGH, one_hi);
    write_reg(CFG_LATCH_LEDS, latch);
    write_reg(CFG_INVERT, inv);
  endtask

  initial begin
    int unsigned leds, zero_hi, one_hi, latch, span;

    // configuration port idle from time zero
    cfg_write_en = 1'b0;
    cfg_index    = CFG_LED_COUNT;
    cfg_data     = '0;

    // shadow state as after reset
    line_cfg.led_count       = RST_LED_COUNT;
    line_cfg.zero_high_ticks = RST_ZERO_HIGH;
    line_cfg.one_high_ticks  = RST_ONE_HIGH;
    line_cfg.latch_leds      = RST_LATCH_LEDS;
    line_cfg.invert_output   = 1'b0;
    wave_running = 1'b0;
    held_rgb     = '0;
    slot_tick    = '0;
    bit_idx      = '0;
    led_pos      = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values: idle tick, start with all ones, then a start while
    // busy that must be refused
    queue_ticks(1);
    queue_start(24'hFFFFFF);
    queue_ticks(3);
    queue_start(24'h000000);
    queue_ticks(2);
    wait_drained();

    // every register but the led count at its top value, inverted line; the transfer keeps going
    // and the registers take effect mid-slot
    apply_setting(65000, 32767, 32767, 255, 1);
    queue_ticks(3);
    queue_start(24'h5A5A5A);
    queue_ticks(1);
    wait_drained();

    // all registers zero: one-tick slots with the line held low, no data leds
    // and no latch gap, so the running transfer ends at the next led boundary
    apply_setting(0, 0, 0, 0, 0);
    queue_ticks(26);
    queue_start(24'h800001);
    queue_ticks(2);
    wait_drained();

    // random part: small settings so whole transfers fit, each phase built from
    // full start-plus-ticks sequences, some cut short and some with a stray start
    while (queued_items < RANDOM_ITEMS) begin
      leds    = $urandom_range(0, 2);
      zero_hi = $urandom_range(0, 2);
      one_hi  = $urandom_range(0, 2);
      latch   = $urandom_range(0, 1);
      apply_setting(leds, zero_hi, one_hi, latch, $urandom_range(0, 1));
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 3) == 0) queue_ticks($urandom_range(1, 4));
        span = (zero_hi + one_hi + 1) * COLOUR_W * ((leds + latch == 0) ? 1 : leds + latch);
        // now and then leave the transfer running into the next setting
        if ($urandom_range(0, 4) == 0) span = $urandom_range(1, span);
        queue_start(COLOUR_W'($urandom()));
        for (int k = 0; k < span; k++) begin
          queue_ticks(1);
          if ($urandom_range(0, 63) == 0) queue_start(COLOUR_W'($urandom()));
        end
        queue_ticks($urandom_range(0, 3));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #400_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
